>>> sv/ctm_pkg.sv
// Shared types, codes and constants for the cascaded reload timer block.
`timescale 1ns / 1ps

package ctm_pkg;

    // Operation codes carried by an input beat
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Byte select inside one timer's four-byte window
    typedef enum logic [1:0] {
        BYTE_LOW   = 2'd0,
        BYTE_HIGH  = 2'd1,
        BYTE_CTL   = 2'd2,
        BYTE_SPARE = 2'd3
    } byte_sel_t;

    // Control byte bit positions
    localparam int CTL_ENABLE_BIT  = 7;
    localparam int CTL_IRQ_BIT     = 6;
    localparam int CTL_CASCADE_BIT = 2;

    localparam int COUNT_W    = 16;
    localparam int PRESCALE_W = 11;
    localparam int MASK_W     = 4;

    // Command from the input stage to every channel
    typedef struct packed {
        logic       tick;
        logic       wr;
        logic [1:0] timer_sel;
        byte_sel_t  byte_sel;
        logic [7:0] data;
    } chan_cmd_t;

    // Readable state of one channel
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [7:0]         ctl_low;
        logic [7:0]         ctl_high;
    } chan_stat_t;

    // Prescaler period for a select code: 1, 64, 256 or 1024 ticks
    function automatic logic [PRESCALE_W-1:0] prescale_period(input logic [1:0] sel);
        logic [PRESCALE_W-1:0] period;
        unique case (sel)
            2'd0:    period = PRESCALE_W'(1);
            2'd1:    period = PRESCALE_W'(64);
            2'd2:    period = PRESCALE_W'(256);
            default: period = PRESCALE_W'(1024);
        endcase
        return period;
    endfunction

endpackage

>>> sv/ctm_channel.sv
// One timer channel: reload latch, control bytes, prescaler and 16-bit counter.
`timescale 1ns / 1ps

module ctm_channel
    import ctm_pkg::*;
#(
    parameter int CHAN_INDEX = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  chan_cmd_t  cmd,
    input  logic       prev_ovf,
    output logic       ovf,
    output logic       irq,
    output chan_stat_t stat
);

    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [COUNT_W-1:0]    reload_reg, reload_next;
    logic [7:0]            ctl_low_reg, ctl_low_next;
    logic [7:0]            ctl_high_reg, ctl_high_next;
    logic [PRESCALE_W-1:0] presc_reg, presc_next;

    logic                  selected;
    logic                  enabled;
    logic                  cascaded;
    logic                  fire;
    logic [PRESCALE_W-1:0] presc_inc;

    assign selected  = (cmd.timer_sel == 2'(CHAN_INDEX));
    assign enabled   = ctl_low_reg[CTL_ENABLE_BIT];
    assign cascaded  = (CHAN_INDEX != 0) && ctl_low_reg[CTL_CASCADE_BIT];
    assign presc_inc = presc_reg + PRESCALE_W'(1);

    always_comb
    begin
        count_next    = count_reg;
        reload_next   = reload_reg;
        ctl_low_next  = ctl_low_reg;
        ctl_high_next = ctl_high_reg;
        presc_next    = presc_reg;
        fire          = 1'b0;
        ovf           = 1'b0;

        if (cmd.tick && enabled)
        begin
            if (cascaded)
            begin
                fire = prev_ovf;
            end
            else if (presc_inc >= prescale_period(ctl_low_reg[1:0]))
            begin
                fire       = 1'b1;
                presc_next = '0;
            end
            else
            begin
                presc_next = presc_inc;
            end

            if (fire)
            begin
                if (count_reg == {COUNT_W{1'b1}})
                begin
                    ovf        = 1'b1;
                    count_next = reload_reg;
                end
                else
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
        end

        if (cmd.wr && selected)
        begin
            unique case (cmd.byte_sel)
                BYTE_LOW:   reload_next[7:0]  = cmd.data;
                BYTE_HIGH:  reload_next[15:8] = cmd.data;
                BYTE_CTL:
                begin
                    // rising enable loads the counter from the latch
                    if (!enabled && cmd.data[CTL_ENABLE_BIT])
                        count_next = reload_reg;
                    ctl_low_next = cmd.data;
                end
                BYTE_SPARE: ctl_high_next = cmd.data;
            endcase
        end
    end

    assign irq           = ovf && ctl_low_reg[CTL_IRQ_BIT];
    assign stat.count    = count_reg;
    assign stat.ctl_low  = ctl_low_reg;
    assign stat.ctl_high = ctl_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            reload_reg   <= '0;
            ctl_low_reg  <= '0;
            ctl_high_reg <= '0;
            presc_reg    <= '0;
        end
        else if (step)
        begin
            count_reg    <= count_next;
            reload_reg   <= reload_next;
            ctl_low_reg  <= ctl_low_next;
            ctl_high_reg <= ctl_high_next;
            presc_reg    <= presc_next;
        end
    end

endmodule

>>> sv/four_channel_cascade_timer.sv
// Top level of the four-channel cascaded reload timer with byte register window.
`timescale 1ns / 1ps

// Channel   Handshake             Fields
// input     in_valid / in_ready   operation, reg_offset, write_data
// output    out_valid / out_ready read_data, overflow_mask, irq_mask
//
// Each beat passes through the input register and then the result register,
// and one beat is taken every cycle while the result is not stalled.
// The channel state updates at the edge a beat moves from the input register
// to the result register, so the next beat sees it directly.
// Reset clears all counters, latches, control bytes and prescalers.
// A stalled result holds its register; the input register still takes a beat
// while it is empty and holds it until the result register frees up.

module four_channel_cascade_timer
    import ctm_pkg::*;
#(
    parameter int NUM_TIMERS = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        operation,
    input  logic [3:0]        reg_offset,
    input  logic [7:0]        write_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        read_data,
    output logic [MASK_W-1:0] overflow_mask,
    output logic [MASK_W-1:0] irq_mask
);

    // Input register
    logic       in_valid_reg;
    logic [1:0] op_reg;
    logic [3:0] offset_reg;
    logic [7:0] data_reg;

    // Result register
    logic              out_valid_reg;
    logic [7:0]        read_data_reg, read_data_next;
    logic [MASK_W-1:0] ovf_mask_reg, ovf_mask_next;
    logic [MASK_W-1:0] irq_mask_reg, irq_mask_next;

    logic       step;
    chan_cmd_t  cmd;

    chan_stat_t      stat [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] ovf_chain;
    logic [NUM_TIMERS-1:0] ovf_vec;
    logic [NUM_TIMERS-1:0] irq_vec;

    // Advance the held beat whenever the result register is free or drains now
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    assign cmd.tick      = (op_t'(op_reg) == OP_TICK);
    assign cmd.wr        = (op_t'(op_reg) == OP_WRITE);
    assign cmd.timer_sel = offset_reg[3:2];
    assign cmd.byte_sel  = byte_sel_t'(offset_reg[1:0]);
    assign cmd.data      = data_reg;

    // Timer 0 has no predecessor; each later timer sees the overflow of the
    // one before it in this same tick.
    assign ovf_chain[0] = 1'b0;

    for (genvar i = 0; i < NUM_TIMERS; i++)
    begin : g_chan
        ctm_channel #(
            .CHAN_INDEX (i)
        ) u_chan (
            .clk      (clk),
            .rst_n    (rst_n),
            .step     (step),
            .cmd      (cmd),
            .prev_ovf (ovf_chain[i]),
            .ovf      (ovf_vec[i]),
            .irq      (irq_vec[i]),
            .stat     (stat[i])
        );
        if (i + 1 < NUM_TIMERS)
        begin : g_link
            assign ovf_chain[i+1] = ovf_vec[i];
        end
    end

    // Build the result: read byte, or overflow and interrupt masks on a tick
    always_comb
    begin
        read_data_next = '0;
        ovf_mask_next  = '0;
        irq_mask_next  = '0;

        if (cmd.tick)
        begin
            ovf_mask_next = MASK_W'(ovf_vec);
            irq_mask_next = MASK_W'(irq_vec);
        end

        if (op_t'(op_reg) == OP_READ)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                if (cmd.timer_sel == 2'(i))
                begin
                    unique case (cmd.byte_sel)
                        BYTE_LOW:   read_data_next = stat[i].count[7:0];
                        BYTE_HIGH:  read_data_next = stat[i].count[15:8];
                        BYTE_CTL:   read_data_next = stat[i].ctl_low;
                        BYTE_SPARE: read_data_next = stat[i].ctl_high;
                    endcase
                end
            end
        end
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (step)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg     <= operation;
            offset_reg <= reg_offset;
            data_reg   <= write_data;
        end
        if (step)
        begin
            read_data_reg <= read_data_next;
            ovf_mask_reg  <= ovf_mask_next;
            irq_mask_reg  <= irq_mask_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = read_data_reg;
    assign overflow_mask = ovf_mask_reg;
    assign irq_mask      = irq_mask_reg;

`ifndef SYNTHESIS
    // An interrupt is only reported for a timer that overflowed
    a_irq_in_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((irq_mask_reg & ~ovf_mask_reg) == '0))
        else $error("irq mask reports a timer without overflow");

    // A read beat never carries overflow bits
    a_read_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (read_data_reg != 8'd0)) |-> (ovf_mask_reg == '0))
        else $error("nonzero read byte together with overflow bits");

    // Timers that are not built never report overflow
    a_ovf_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((ovf_mask_reg >> NUM_TIMERS) == '0))
        else $error("overflow reported for a timer that does not exist");

    // A stepped beat always lands in the result register
    a_step_lands: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("stepped beat lost before the result register");
`endif

endmodule
